[hw/rtl/gfr_pkg.sv]
// ---------------------------------------------------------------------------
// Gamepad frame receiver package
// Shared constants and codes for the gamepad frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package gfr_pkg;

    // Width in bits of the elapsed-time counter, which counts milliseconds.
    localparam int ELAPSED_WIDTH = 32;

    localparam int FRAME_LEN  = 12;
    localparam int COUNT_SAT  = 13;
    localparam int CFG_WIDTH  = 16;
    localparam int OUT_WIDTH  = 80;

    localparam logic [7:0] OFFSET      = 8'h20;
    localparam logic [7:0] NEWLINE     = 8'h0A;
    localparam logic [7:0] STICK_RESET = 8'd127;

    typedef enum logic [2:0] {
        STATUS_NONE     = 3'd0,
        STATUS_OK       = 3'd1,
        STATUS_BAD_LEN  = 3'd2,
        STATUS_BAD_SUM  = 3'd3,
        STATUS_BAD_BTN  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT_EN  = 2'd0,
        CFG_TIMEOUT_MS  = 2'd1,
        CFG_TICK_MS     = 2'd2,
        CFG_MAX_PRESSED = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

endpackage

`default_nettype wire

[hw/rtl/gamepad_frame_receiver_core.sv]
// ---------------------------------------------------------------------------
// Gamepad frame receiver core
// Collects serial bytes into 12-byte frames, checks and unpacks them, and
// tracks link liveness from timer ticks.
// ---------------------------------------------------------------------------
// Every input word (a received byte or a timer tick) yields exactly one
// output word carrying a status code and the currently held controller
// state. The block takes one word per clock cycle while s_tready is high:
// the frame bytes live in twelve registers with a running checksum and
// counter, so a newline is checked and decoded in the same cycle it
// arrives, and the result is registered in a single output register on
// acceptance. s_tready stays high whenever that register is empty or being
// read, so throughput is one word per cycle under a free-flowing consumer.
`default_nettype none

module gamepad_frame_receiver_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]                    s_tuser,   // [0] action
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [2:0] status, [20:3] buttons, [31:21] extra_buttons, [39:32] left_x,
    // [47:40] left_y, [55:48] right_x, [63:56] right_y, [66:64] aux_buttons,
    // [68:67] side_buttons, [76:69] raw_third_byte, [77] link_alive
    output logic [gfr_pkg::OUT_WIDTH-1:0]      m_tdata,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [gfr_pkg::CFG_WIDTH-1:0] cfg_wdata
);
    import gfr_pkg::*;

    localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

    // Configuration registers
    logic        timeout_en_reg;
    logic [15:0] timeout_ms_reg;
    logic [9:0]  tick_ms_reg;
    logic [4:0]  max_pressed_reg;

    // Receiver state
    logic [7:0]               frame_reg [FRAME_LEN];
    logic [3:0]               byte_count_reg, byte_count_next;
    logic [5:0]               xor_reg, xor_next;
    logic [ELAPSED_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [17:0]              buttons_reg, buttons_next;
    logic [10:0]              extra_reg, extra_next;
    logic [7:0]               sticks_reg [4];
    logic [7:0]               sticks_next [4];
    logic [2:0]               aux_reg, aux_next;
    logic [1:0]               side_reg, side_next;
    logic [7:0]               raw_reg, raw_next;

    // Output register
    logic                     m_valid_reg;
    logic [OUT_WIDTH-1:0]     m_data_reg, m_data_next;

    logic      s_accept;
    status_t   status_next;
    logic      is_tick;
    logic      is_newline;
    logic      store_en;
    logic [7:0] rx_off;

    // Decode of the stored frame
    logic [7:0]  d [FRAME_LEN-1];
    logic [17:0] dec_buttons;
    logic [10:0] dec_extra;
    logic [7:0]  dec_lx, dec_ly, dec_rx, dec_ry;
    logic [4:0]  pressed;
    logic [7:0]  last_byte;
    logic [7:0]  last_off;
    logic        sum_ok;
    logic [ELAPSED_WIDTH:0] elapsed_sum;
    logic        link_alive;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign is_tick    = (s_tuser[0] == ACT_TICK);
    assign is_newline = !is_tick && (s_tdata == NEWLINE);
    assign rx_off     = s_tdata - OFFSET;
    assign store_en   = s_accept && !is_tick && !is_newline
                        && (byte_count_reg < 4'(FRAME_LEN));

    always_comb begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            d[i] = frame_reg[i] - OFFSET;
        end
        dec_buttons = {d[2][5:0], d[1][5:0], d[0][5:0]};
        dec_extra   = {d[4][4:0], d[3][5:0]};
        dec_lx      = ~(d[5] | {d[6][1:0], 6'b0});
        dec_ly      = ~{d[7][3:0], d[6][5:2]};
        dec_rx      = ~{d[8][5:0], d[7][5:4]};
        dec_ry      = ~(d[9] | {d[10][1:0], 6'b0});
        pressed     = '0;
        for (int i = 0; i < 16; i++) begin
            pressed = pressed + 5'(dec_buttons[i]);
        end
    end

    // The check byte must sit in the printable window and match the XOR.
    assign last_byte = frame_reg[FRAME_LEN-1];
    assign last_off  = last_byte - OFFSET;
    assign sum_ok    = (last_byte >= OFFSET) && (last_off[7:6] == 2'b00)
                       && (last_off[5:0] == xor_reg);

    assign elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_WIDTH+1)'(tick_ms_reg);

    always_comb begin
        byte_count_next = byte_count_reg;
        xor_next        = xor_reg;
        elapsed_next    = elapsed_reg;
        buttons_next    = buttons_reg;
        extra_next      = extra_reg;
        sticks_next     = sticks_reg;
        aux_next        = aux_reg;
        side_next       = side_reg;
        raw_next        = raw_reg;
        status_next     = STATUS_NONE;

        if (is_tick) begin
            elapsed_next = elapsed_sum[ELAPSED_WIDTH] ? ELAPSED_MAX
                                                      : elapsed_sum[ELAPSED_WIDTH-1:0];
        end else if (is_newline) begin
            byte_count_next = '0;
            xor_next        = '0;
            if (byte_count_reg != 4'(FRAME_LEN)) begin
                status_next = STATUS_BAD_LEN;
            end else if (!sum_ok) begin
                status_next = STATUS_BAD_SUM;
            end else begin
                extra_next     = dec_extra;
                sticks_next[0] = dec_lx;
                sticks_next[1] = dec_ly;
                sticks_next[2] = dec_rx;
                sticks_next[3] = dec_ry;
                aux_next       = d[10][4:2];
                side_next      = {d[10][5], d[4][5]};
                raw_next       = frame_reg[2];
                elapsed_next   = '0;
                if (pressed > max_pressed_reg) begin
                    status_next = STATUS_BAD_BTN;
                end else begin
                    status_next  = STATUS_OK;
                    buttons_next = dec_buttons;
                end
            end
        end else begin
            if (byte_count_reg < 4'(FRAME_LEN - 1)) begin
                xor_next = xor_reg ^ rx_off[5:0];
            end
            if (byte_count_reg < 4'(COUNT_SAT)) begin
                byte_count_next = byte_count_reg + 4'd1;
            end
        end
    end

    assign link_alive = !timeout_en_reg
                        || (elapsed_next < ELAPSED_WIDTH'(timeout_ms_reg));

    always_comb begin
        m_data_next = {2'b00, link_alive, raw_next, side_next, aux_next,
                       sticks_next[3], sticks_next[2], sticks_next[1], sticks_next[0],
                       extra_next, buttons_next, status_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_en_reg  <= 1'b0;
            timeout_ms_reg  <= '0;
            tick_ms_reg     <= 10'd1;
            max_pressed_reg <= 5'd5;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_TIMEOUT_EN:  timeout_en_reg  <= cfg_wdata[0];
                CFG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_wdata[15:0];
                CFG_TICK_MS:     tick_ms_reg     <= cfg_wdata[9:0];
                CFG_MAX_PRESSED: max_pressed_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // Frame bytes carry no reset; they are only read after being written.
    always_ff @(posedge aclk) begin
        if (store_en) begin
            frame_reg[byte_count_reg] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            xor_reg        <= '0;
            elapsed_reg    <= ELAPSED_MAX;
            buttons_reg    <= '0;
            extra_reg      <= '0;
            for (int i = 0; i < 4; i++) begin
                sticks_reg[i] <= STICK_RESET;
            end
            aux_reg        <= '0;
            side_reg       <= '0;
            raw_reg        <= '0;
        end else if (s_accept) begin
            byte_count_reg <= byte_count_next;
            xor_reg        <= xor_next;
            elapsed_reg    <= elapsed_next;
            buttons_reg    <= buttons_next;
            extra_reg      <= extra_next;
            sticks_reg     <= sticks_next;
            aux_reg        <= aux_next;
            side_reg       <= side_next;
            raw_reg        <= raw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // The byte counter saturates and never runs past the long-line mark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= 4'(COUNT_SAT))
        else $error("byte counter beyond saturation");

    // A newline always restarts frame collection.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_newline |=> byte_count_reg == '0 && xor_reg == '0)
        else $error("newline did not clear frame collection");

    // A frame that passes the checksum restarts the link timer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (status_next == STATUS_OK || status_next == STATUS_BAD_BTN)
        |=> elapsed_reg == '0)
        else $error("good frame did not restart link timer");

    // Ticks never make the elapsed time go backward.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_tick |=> elapsed_reg >= $past(elapsed_reg))
        else $error("elapsed time decreased on tick");

    // Input is only held off while a result waits in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_valid_reg)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

[test/gamepad_frame_receiver_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gamepad frame receiver core testbench
// Drives serial bytes and timer ticks into the core with random idle gaps on
// both streams. A scoreboard tracks the expected frame, checksum, held pad
// state and link timer, and compares every output word field by field.
// ---------------------------------------------------------------------------
module gamepad_frame_receiver_core_tb;

    import gfr_pkg::*;

    typedef struct {
        status_t     status;
        logic [17:0] buttons;
        logic [10:0] extra;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [2:0]  aux;
        logic [1:0]  side;
        logic [7:0]  raw;
        logic        alive;
    } pad_report_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_SHORT,
        FR_LONG
    } frame_kind_t;

    // Tracks the receiver state and holds the reports still to come out.
    class pad_report_tracker;
        logic [7:0]               frame_bytes [FRAME_LEN];
        logic [3:0]               count;
        logic [5:0]               xsum;
        logic [ELAPSED_WIDTH-1:0] elapsed;
        logic [17:0]              buttons;
        logic [10:0]              extra;
        logic [7:0]               sticks [4];
        logic [2:0]               aux;
        logic [1:0]               side;
        logic [7:0]               raw;
        logic                     tmo_en;
        logic [15:0]              tmo_ms;
        logic [9:0]               tick_ms;
        logic [4:0]               max_pressed;
        pad_report_t              expected_reports [$];
        int                       errors;

        function new();
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
            count       = '0;
            xsum        = '0;
            elapsed     = '1;
            buttons     = '0;
            extra       = '0;
            foreach (sticks[i]) sticks[i] = STICK_RESET;
            aux         = '0;
            side        = '0;
            raw         = '0;
            tmo_en      = 1'b0;
            tmo_ms      = '0;
            tick_ms     = 10'd1;
            max_pressed = 5'd5;
            errors      = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_WIDTH-1:0] v);
            case (idx)
                CFG_TIMEOUT_EN:  tmo_en      = v[0];
                CFG_TIMEOUT_MS:  tmo_ms      = v[15:0];
                CFG_TICK_MS:     tick_ms     = v[9:0];
                CFG_MAX_PRESSED: max_pressed = v[4:0];
                default: ;
            endcase
        endfunction

        function status_t unpack_frame();
            logic [7:0]  d [FRAME_LEN];
            logic [17:0] btn;
            foreach (d[i]) d[i] = frame_bytes[i] - OFFSET;
            btn       = {d[2][5:0], d[1][5:0], d[0][5:0]};
            extra     = {d[4][4:0], d[3][5:0]};
            sticks[0] = ~(d[5] | {d[6][1:0], 6'b0});
            sticks[1] = ~{d[7][3:0], d[6][5:2]};
            sticks[2] = ~{d[8][5:0], d[7][5:4]};
            sticks[3] = ~(d[9] | {d[10][1:0], 6'b0});
            aux       = d[10][4:2];
            side      = {d[10][5], d[4][5]};
            raw       = frame_bytes[2];
            elapsed   = '0;
            // Too many of the low sixteen buttons: keep the old buttons.
            if ($countones(btn[15:0]) > max_pressed) return STATUS_BAD_BTN;
            buttons = btn;
            return STATUS_OK;
        endfunction

        function void note_word(action_t act, logic [7:0] b);
            pad_report_t            rep;
            status_t                st;
            logic [ELAPSED_WIDTH:0] sum;
            logic [7:0]             last;
            st = STATUS_NONE;
            if (act == ACT_TICK) begin
                sum = {1'b0, elapsed} + tick_ms;
                elapsed = sum[ELAPSED_WIDTH] ? '1 : sum[ELAPSED_WIDTH-1:0];
            end else if (b == NEWLINE) begin
                if (count != FRAME_LEN) begin
                    st = STATUS_BAD_LEN;
                end else begin
                    last = frame_bytes[FRAME_LEN-1];
                    if (last < OFFSET || (last - OFFSET) != {2'b00, xsum})
                        st = STATUS_BAD_SUM;
                    else
                        st = unpack_frame();
                end
                count = '0;
                xsum  = '0;
            end else begin
                if (count < FRAME_LEN) begin
                    frame_bytes[count] = b;
                    if (count < FRAME_LEN - 1) xsum ^= 6'(b - OFFSET);
                end
                if (count < COUNT_SAT) count++;
            end
            rep.status  = st;
            rep.buttons = buttons;
            rep.extra   = extra;
            rep.left_x  = sticks[0];
            rep.left_y  = sticks[1];
            rep.right_x = sticks[2];
            rep.right_y = sticks[3];
            rep.aux     = aux;
            rep.side    = side;
            rep.raw     = raw;
            rep.alive   = !tmo_en || (elapsed < {{(ELAPSED_WIDTH-16){1'b0}}, tmo_ms});
            expected_reports.push_back(rep);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(logic [OUT_WIDTH-1:0] w);
            pad_report_t rep;
            if (expected_reports.size() == 0) begin
                $error("output word 0x%0h arrived with nothing expected", w);
                errors++;
                return;
            end
            rep = expected_reports.pop_front();
            compare_field("status",         rep.status,  w[2:0]);
            compare_field("buttons",        rep.buttons, w[20:3]);
            compare_field("extra_buttons",  rep.extra,   w[31:21]);
            compare_field("left_x",         rep.left_x,  w[39:32]);
            compare_field("left_y",         rep.left_y,  w[47:40]);
            compare_field("right_x",        rep.right_x, w[55:48]);
            compare_field("right_y",        rep.right_y, w[63:56]);
            compare_field("aux_buttons",    rep.aux,     w[66:64]);
            compare_field("side_buttons",   rep.side,    w[68:67]);
            compare_field("raw_third_byte", rep.raw,     w[76:69]);
            compare_field("link_alive",     rep.alive,   w[77]);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_WIDTH-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_addr  = '0;
    logic [CFG_WIDTH-1:0]  cfg_wdata = '0;

    pad_report_tracker tracker = new();
    int  items_sent    = 0;
    int  words_checked = 0;
    bit  steady_flow   = 1'b0;

    gamepad_frame_receiver_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly no gap, some short ones and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] content_byte(bit sparse);
        logic [7:0] b;
        if (sparse) begin
            b = OFFSET + 8'($urandom & $urandom & $urandom & 32'h3F);
        end else if ($urandom_range(0, 99) < 85) begin
            b = OFFSET + 8'($urandom_range(0, 63));
        end else begin
            do b = 8'($urandom); while (b == NEWLINE);
        end
        return b;
    endfunction

    task automatic send_word(action_t act, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if ($urandom_range(0, 149) == 0) steady_flow = !steady_flow;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        tracker.note_word(act, b);
        items_sent++;
    endtask

    task automatic send_tick();
        send_word(ACT_TICK, 8'($urandom));
    endtask

    task automatic send_frame(frame_kind_t kind);
        logic [7:0] line [$];
        logic [7:0] b;
        logic [5:0] sum;
        bit         sparse;
        int         len;
        sparse = $urandom_range(0, 1);
        sum    = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            b = content_byte(sparse && i < 3);
            line.push_back(b);
            sum ^= 6'(b - OFFSET);
        end
        case (kind)
            FR_GOOD: line.push_back(OFFSET + 8'(sum));
            FR_BAD_SUM: begin
                case ($urandom_range(0, 2))
                    0: b = OFFSET + 8'(sum ^ 6'($urandom_range(1, 63)));
                    1: do b = 8'($urandom_range(0, 31)); while (b == NEWLINE);
                    default: b = 8'($urandom_range(96, 255));
                endcase
                line.push_back(b);
            end
            FR_SHORT: begin
                len = $urandom_range(0, FRAME_LEN - 1);
                while (line.size() > len) void'(line.pop_back());
            end
            default: begin
                line.push_back(OFFSET + 8'(sum));
                repeat ($urandom_range(1, 8)) line.push_back(content_byte(1'b0));
            end
        endcase
        foreach (line[i]) begin
            if ($urandom_range(0, 11) == 0) send_tick();
            send_word(ACT_BYTE, line[i]);
        end
        send_word(ACT_BYTE, NEWLINE);
    endtask

    // Registers may only change while nothing is in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(logic [CFG_WIDTH-1:0] en, logic [CFG_WIDTH-1:0] tmo,
                             logic [CFG_WIDTH-1:0] tick, logic [CFG_WIDTH-1:0] maxp);
        logic [CFG_WIDTH-1:0] vals [4];
        vals = '{en, tmo, tick, maxp};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= cfg_idx_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            tracker.write_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off that backs up the core.
    initial begin
        int stall_left;
        bit pressure_done;
        stall_left    = 0;
        pressure_done = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                tracker.check_word(m_tdata);
                words_checked++;
            end
            if (!pressure_done && words_checked >= 300) begin
                pressure_done = 1'b1;
                stall_left    = 250;
            end
            if (stall_left == 0) stall_left = pick_gap();
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int r;
        int target;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: link timer saturated, a bare newline, then a frame
        // with every bit set (too many buttons) and one with every bit clear.
        send_tick();
        send_word(ACT_BYTE, NEWLINE);
        repeat (FRAME_LEN) send_word(ACT_BYTE, 8'h5F);
        send_word(ACT_BYTE, NEWLINE);
        repeat (FRAME_LEN) send_word(ACT_BYTE, OFFSET);
        send_word(ACT_BYTE, NEWLINE);

        for (int p = 0; p < 5; p++) begin
            drain();
            case (p)
                0: configure(1, 40, 3, 5);
                1: configure(1, 0, 1, 0);
                2: configure(1, 65535, 1000, 16);
                3: configure(0, 25, 2, 8);
                default: configure(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
            target = items_sent + 300;
            while (items_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    send_frame(FR_GOOD);
                end else if (r < 70) begin
                    send_frame(FR_BAD_SUM);
                end else if (r < 77) begin
                    send_frame(FR_SHORT);
                end else if (r < 84) begin
                    send_frame(FR_LONG);
                end else if (r < 92) begin
                    repeat ($urandom_range(1, 30)) send_tick();
                end else begin
                    repeat ($urandom_range(1, 16))
                        send_word(action_t'($urandom_range(0, 1)),
                                  ($urandom_range(0, 7) == 0) ? NEWLINE : 8'($urandom));
                end
            end
        end

        drain();
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/gfr_pkg.sv
hw/rtl/gamepad_frame_receiver_core.sv
test/gamepad_frame_receiver_core_tb.sv
